/* hw/rtl/trpm_pkg.sv */
`default_nettype none
// ============================================================================
// trpm_pkg
// shared types, codes and constants of the three-level radix page map
// ============================================================================
package trpm_pkg;

    // default node pool sizes
    localparam int DEF_MIDDLE_NODES = 4;
    localparam int DEF_LEAF_NODES   = 16;

    // one radix level: 512 slots, 9 address bits
    localparam int SLOTS  = 512;
    localparam int SLOT_W = 9;

    // low bit of each address field
    localparam int TOP_LSB   = 30;
    localparam int MID_LSB   = 21;
    localparam int LEAF_LSB  = 12;
    localparam int RANGE_LSB = 39;

    localparam logic [63:0] NEG_EINVAL = 64'hFFFF_FFFF_FFFF_FFEA;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_PRESENT = 3'd1,
        ST_ABSENT  = 3'd2,
        ST_RANGE   = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    // write strobes from the sequencer to the table store
    typedef struct packed {
        logic top;
        logic mid;
        logic leaf;
    } trpm_we_t;

endpackage
`default_nettype wire

/* hw/rtl/trpm_req_if.sv */
`default_nettype none
// ============================================================================
// trpm_req_if
// request channel: opcode, page address and value to store
// ============================================================================
interface trpm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [63:0] page_address;
    logic [63:0] entry_value;

    modport source (output valid, output opcode, output page_address,
                    output entry_value, input ready);
    modport sink   (input valid, input opcode, input page_address,
                    input entry_value, output ready);
endinterface
`default_nettype wire

/* hw/rtl/trpm_rsp_if.sv */
`default_nettype none
// ============================================================================
// trpm_rsp_if
// response channel: status code and read value
// ============================================================================
interface trpm_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] read_value;

    modport source (output valid, output status, output read_value, input ready);
    modport sink   (input valid, input status, input read_value, output ready);
endinterface
`default_nettype wire

/* hw/rtl/trpm_tables.sv */
`default_nettype none
// ============================================================================
// trpm_tables
// top, middle and leaf tables as single-port memories with registered
// read data, plus the clearing sweep that runs after reset
// ============================================================================
module trpm_tables
    import trpm_pkg::*;
#(
    parameter int MIDDLE_NODES = DEF_MIDDLE_NODES,
    parameter int LEAF_NODES   = DEF_LEAF_NODES,
    localparam int MID_W       = $clog2(MIDDLE_NODES + 1),
    localparam int LEAF_W      = $clog2(LEAF_NODES + 1),
    localparam int MADDR_W     = $clog2(MIDDLE_NODES * SLOTS),
    localparam int LADDR_W     = $clog2(LEAF_NODES * SLOTS)
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire trpm_we_t           we,
    input  wire logic [SLOT_W-1:0]  top_addr,
    input  wire logic [MID_W-1:0]   top_wdata,
    output logic      [MID_W-1:0]   top_rdata,
    input  wire logic [MADDR_W-1:0] mid_addr,
    input  wire logic [LEAF_W-1:0]  mid_wdata,
    output logic      [LEAF_W-1:0]  mid_rdata,
    input  wire logic [LADDR_W-1:0] leaf_addr,
    input  wire logic [63:0]        leaf_wdata,
    output logic      [63:0]        leaf_rdata,
    output logic                    clear_busy
);

    localparam int MID_DEPTH  = MIDDLE_NODES * SLOTS;
    localparam int LEAF_DEPTH = LEAF_NODES * SLOTS;
    localparam int CLR_DEPTH  = (MIDDLE_NODES > LEAF_NODES) ? MID_DEPTH : LEAF_DEPTH;
    localparam int CLR_W      = $clog2(CLR_DEPTH);

    logic [MID_W-1:0]  top_mem  [SLOTS];
    logic [LEAF_W-1:0] mid_mem  [MID_DEPTH];
    logic [63:0]       leaf_mem [LEAF_DEPTH];

    logic [CLR_W-1:0] clr_idx_reg, clr_idx_next;
    logic             clr_busy_reg, clr_busy_next;

    logic               top_we, mid_we, leaf_we;
    logic [SLOT_W-1:0]  top_a;
    logic [MADDR_W-1:0] mid_a;
    logic [LADDR_W-1:0] leaf_a;
    logic [MID_W-1:0]   top_d;
    logic [LEAF_W-1:0]  mid_d;
    logic [63:0]        leaf_d;

    // clearing sweep, one address per cycle of every memory still within its depth
    always_comb
    begin
        clr_idx_next  = clr_idx_reg + 1'b1;
        clr_busy_next = clr_busy_reg && (clr_idx_reg != CLR_W'(CLR_DEPTH - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_idx_reg  <= clr_idx_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    assign clear_busy = clr_busy_reg;

    always_comb
    begin
        if (clr_busy_reg)
        begin
            top_we  = ({1'b0, clr_idx_reg} < (CLR_W + 1)'(SLOTS));
            mid_we  = ({1'b0, clr_idx_reg} < (CLR_W + 1)'(MID_DEPTH));
            leaf_we = ({1'b0, clr_idx_reg} < (CLR_W + 1)'(LEAF_DEPTH));
            top_a   = clr_idx_reg[SLOT_W-1:0];
            mid_a   = clr_idx_reg[MADDR_W-1:0];
            leaf_a  = clr_idx_reg[LADDR_W-1:0];
            top_d   = '0;
            mid_d   = '0;
            leaf_d  = '0;
        end
        else
        begin
            top_we  = we.top;
            mid_we  = we.mid;
            leaf_we = we.leaf;
            top_a   = top_addr;
            mid_a   = mid_addr;
            leaf_a  = leaf_addr;
            top_d   = top_wdata;
            mid_d   = mid_wdata;
            leaf_d  = leaf_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (top_we)
        begin
            top_mem[top_a] <= top_d;
        end
        top_rdata <= top_mem[top_a];
    end

    always_ff @(posedge clk)
    begin
        if (mid_we)
        begin
            mid_mem[mid_a] <= mid_d;
        end
        mid_rdata <= mid_mem[mid_a];
    end

    always_ff @(posedge clk)
    begin
        if (leaf_we)
        begin
            leaf_mem[leaf_a] <= leaf_d;
        end
        leaf_rdata <= leaf_mem[leaf_a];
    end

endmodule
`default_nettype wire

/* hw/rtl/three_level_radix_page_map.sv */
`default_nettype none
// ============================================================================
// three_level_radix_page_map
// page address to 64-bit value map kept as a three-level radix tree with
// bump-allocated middle and leaf nodes
// ============================================================================
//
//  port  dir  handshake      payload
//  ----  ---  -------------  ---------------------------------------------
//  req   in   valid / ready  opcode, page_address, entry_value
//  rsp   out  valid / ready  status, read_value
//
//  a transaction steps through accept, middle read, leaf read and final
//  update, following the chain of three dependent reads through the
//  registered memories; unused opcodes and out-of-range addresses answer from the middle step
//  after reset the tables are swept to zero, one address a cycle over
//  max(MIDDLE_NODES, LEAF_NODES) * 512 entries; req.ready stays low meanwhile
//  one transaction at a time; req.ready is high only while the sequencer is
//  idle, and a new request may be taken while the last response still waits
//  a stalled rsp holds the sequencer in the step that posts the response until the slot frees
//
module three_level_radix_page_map
    import trpm_pkg::*;
#(
    parameter int MIDDLE_NODES = DEF_MIDDLE_NODES,
    parameter int LEAF_NODES   = DEF_LEAF_NODES,
    localparam int MID_W       = $clog2(MIDDLE_NODES + 1),
    localparam int LEAF_W      = $clog2(LEAF_NODES + 1),
    localparam int MADDR_W     = $clog2(MIDDLE_NODES * SLOTS),
    localparam int LADDR_W     = $clog2(LEAF_NODES * SLOTS)
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    trpm_req_if.sink    req,
    trpm_rsp_if.source  rsp
);

    // sequencer steps: each one consumes the read issued by the one before
    typedef enum logic [1:0] {
        S_IDLE,   // take a request, read the top table
        S_MID,    // top entry known, read the middle node
        S_LEAF,   // leaf node known, allocate nodes, read the leaf entry
        S_FINAL   // leaf entry known, update it and post the response
    } state_t;

    state_t state_reg, state_next;

    // response register, parts the sequencer from the rsp side
    logic          out_valid_reg, out_valid_next;
    status_t       out_status_reg, out_status_next;
    logic [63:0]   out_value_reg, out_value_next;

    // pool bump counters
    logic [MID_W-1:0]  middle_used_reg, middle_used_next;
    logic [LEAF_W-1:0] leaf_used_reg, leaf_used_next;

    // request held over the walk
    logic [1:0]        op_reg, op_next;
    logic [SLOT_W-1:0] i2_reg, i2_next;
    logic [SLOT_W-1:0] i1_reg, i1_next;
    logic [SLOT_W-1:0] i0_reg, i0_next;
    logic [63:0]       value_reg, value_next;
    logic              range_reg, range_next;
    logic [MID_W-1:0]  mid_node_reg, mid_node_next;
    logic [LEAF_W-1:0] leaf_node_reg, leaf_node_next;
    logic              full_reg, full_next;

    // table store
    trpm_we_t           we;
    logic [SLOT_W-1:0]  top_addr;
    logic [MID_W-1:0]   top_wdata, top_rdata;
    logic [MADDR_W-1:0] mid_addr;
    logic [LEAF_W-1:0]  mid_wdata, mid_rdata;
    logic [LADDR_W-1:0] leaf_addr;
    logic [63:0]        leaf_wdata, leaf_rdata;
    logic               clear_busy;

    // walk decisions
    logic              accept, out_free, is_insert;
    logic              mid_ok, need_mid, need_leaf, pool_full, alloc;
    logic [MID_W-1:0]  mid_new, mid_eff, mid_sel;
    logic [LEAF_W-1:0] leaf_cur, leaf_new, leaf_eff, leaf_sel;
    status_t           res_status;
    logic [63:0]       res_value;
    logic              leaf_wr;

    trpm_tables #(
        .MIDDLE_NODES (MIDDLE_NODES),
        .LEAF_NODES   (LEAF_NODES)
    ) u_tables (
        .clk        (clk),
        .rst_n      (rst_n),
        .we         (we),
        .top_addr   (top_addr),
        .top_wdata  (top_wdata),
        .top_rdata  (top_rdata),
        .mid_addr   (mid_addr),
        .mid_wdata  (mid_wdata),
        .mid_rdata  (mid_rdata),
        .leaf_addr  (leaf_addr),
        .leaf_wdata (leaf_wdata),
        .leaf_rdata (leaf_rdata),
        .clear_busy (clear_busy)
    );

    assign req.ready      = (state_reg == S_IDLE) && !clear_busy;
    assign accept         = req.valid && req.ready;
    assign out_free       = !out_valid_reg || rsp.ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.read_value = out_value_reg;

    // node decode: a pointer beyond the pool counts as no child
    assign mid_ok    = (top_rdata != '0) && (top_rdata <= MID_W'(MIDDLE_NODES));
    assign leaf_cur  = ((mid_node_reg != '0) && (mid_rdata != '0) &&
                        (mid_rdata <= LEAF_W'(LEAF_NODES))) ? mid_rdata : '0;
    assign is_insert = (op_reg == OP_INSERT);
    assign need_mid  = (mid_node_reg == '0);
    assign need_leaf = need_mid || (leaf_cur == '0);
    assign pool_full = (need_mid && (middle_used_reg >= MID_W'(MIDDLE_NODES))) ||
                       (need_leaf && (leaf_used_reg >= LEAF_W'(LEAF_NODES)));
    assign alloc     = is_insert && !pool_full;
    assign mid_new   = middle_used_reg + 1'b1;
    assign leaf_new  = leaf_used_reg + 1'b1;
    assign mid_eff   = (alloc && need_mid) ? mid_new : mid_node_reg;
    assign leaf_eff  = (alloc && need_leaf) ? leaf_new : leaf_cur;

    // memory addresses follow the step that reads them
    assign mid_sel   = (state_reg == S_MID) ? top_rdata : mid_eff;
    assign leaf_sel  = (state_reg == S_LEAF) ? leaf_eff : leaf_node_reg;
    assign top_addr  = (state_reg == S_IDLE) ? req.page_address[TOP_LSB +: SLOT_W]
                                             : i2_reg;
    assign mid_addr  = MADDR_W'({mid_sel - 1'b1, i1_reg});
    assign leaf_addr = LADDR_W'({leaf_sel - 1'b1, i0_reg});
    assign top_wdata  = mid_new;
    assign mid_wdata  = leaf_new;
    assign leaf_wdata = is_insert ? value_reg : '0;

    // leaf step outcome
    always_comb
    begin
        res_status = ST_OK;
        res_value  = '0;
        leaf_wr    = 1'b0;
        case (op_reg)
            OP_INSERT:
            begin
                if (full_reg)
                begin
                    res_status = ST_FULL;
                end
                else if (leaf_rdata != '0)
                begin
                    res_status = ST_PRESENT;
                end
                else
                begin
                    leaf_wr = (state_reg == S_FINAL) && out_free;
                end
            end
            OP_REMOVE:
            begin
                if ((leaf_node_reg == '0) || (leaf_rdata == '0))
                begin
                    res_status = ST_ABSENT;
                end
                else
                begin
                    leaf_wr = (state_reg == S_FINAL) && out_free;
                end
            end
            OP_SEARCH:
            begin
                if (leaf_node_reg == '0)
                begin
                    res_status = ST_ABSENT;
                    res_value  = NEG_EINVAL;
                end
                else
                begin
                    res_value = leaf_rdata;
                    if (leaf_rdata == '0)
                    begin
                        res_status = ST_ABSENT;
                    end
                end
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_value_next   = out_value_reg;
        middle_used_next = middle_used_reg;
        leaf_used_next   = leaf_used_reg;
        op_next          = op_reg;
        i2_next          = i2_reg;
        i1_next          = i1_reg;
        i0_next          = i0_reg;
        value_next       = value_reg;
        range_next       = range_reg;
        mid_node_next    = mid_node_reg;
        leaf_node_next   = leaf_node_reg;
        full_next        = full_reg;
        we.top           = 1'b0;
        we.mid           = 1'b0;
        we.leaf          = leaf_wr;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = req.opcode;
                    i2_next    = req.page_address[TOP_LSB +: SLOT_W];
                    i1_next    = req.page_address[MID_LSB +: SLOT_W];
                    i0_next    = req.page_address[LEAF_LSB +: SLOT_W];
                    value_next = req.entry_value;
                    range_next = |req.page_address[RANGE_LSB +: SLOT_W];
                    state_next = S_MID;
                end
            end
            S_MID:
            begin
                mid_node_next = mid_ok ? top_rdata : '0;
                if ((op_reg != OP_INSERT) && (op_reg != OP_REMOVE) &&
                    (op_reg != OP_SEARCH))
                begin
                    // unused opcode: no change, zero response
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_OK;
                        out_value_next  = '0;
                        state_next      = S_IDLE;
                    end
                end
                else if (range_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_RANGE;
                        out_value_next  = (op_reg == OP_SEARCH) ? NEG_EINVAL : '0;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_LEAF;
                end
            end
            S_LEAF:
            begin
                // on an insert, take missing nodes from the pools, unless one is used up
                we.top         = alloc && need_mid;
                we.mid         = alloc && need_leaf;
                if (alloc && need_mid)
                begin
                    middle_used_next = mid_new;
                end
                if (alloc && need_leaf)
                begin
                    leaf_used_next = leaf_new;
                end
                full_next      = is_insert && pool_full;
                leaf_node_next = leaf_eff;
                state_next     = S_FINAL;
            end
            S_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status;
                    out_value_next  = res_value;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= ST_OK;
            out_value_reg   <= '0;
            middle_used_reg <= '0;
            leaf_used_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            out_status_reg  <= out_status_next;
            out_value_reg   <= out_value_next;
            middle_used_reg <= middle_used_next;
            leaf_used_reg   <= leaf_used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        i2_reg        <= i2_next;
        i1_reg        <= i1_next;
        i0_reg        <= i0_next;
        value_reg     <= value_next;
        range_reg     <= range_next;
        mid_node_reg  <= mid_node_next;
        leaf_node_reg <= leaf_node_next;
        full_reg      <= full_next;
    end

    // pools never run past their size
    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (middle_used_reg <= MID_W'(MIDDLE_NODES)) &&
        (leaf_used_reg <= LEAF_W'(LEAF_NODES)))
        else $error("node pool counter past pool size");

    // the leaf counter only ever steps up by one
    a_leaf_bump: assert property (@(posedge clk) disable iff (!rst_n)
        (leaf_used_reg != $past(leaf_used_reg)) |->
        (leaf_used_reg == $past(leaf_used_reg) + 1'b1))
        else $error("leaf pool counter moved by other than one");

    // node links are written only by an insert in its allocation step
    a_link_write: assert property (@(posedge clk) disable iff (!rst_n)
        (we.top || we.mid) |->
        ((state_reg == S_LEAF) && (op_reg == OP_INSERT) && !clear_busy))
        else $error("node link written outside insert allocation");

    // an exhausted pool leaves the leaf entry untouched
    a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FINAL) && full_reg) |-> !we.leaf)
        else $error("leaf written although the pool was exhausted");

    // a request taken starts the walk
    a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_MID))
        else $error("accepted request did not start the walk");

endmodule
`default_nettype wire
